@@ design/ppsm_pkg.sv @@
`timescale 1ns / 1ps

package ppsm_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN       = 24;
    localparam int NUM_STAGES    = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

    // datapath widths
    localparam int XW  = 36;              // cordic x/y, units of 2^-31
    localparam int ZW  = ANGLE_BITS + 2;  // residual angle
    localparam int DW  = 22;              // point/centre differences, units of 2^-15
    localparam int SQW = 2 * DW;

    localparam int QDEPTH = 32;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [16:0] INV_GAIN  = 17'd39797;
    localparam logic [16:0] COS30_Q16 = 17'd56756;

    // shape codes
    localparam logic [2:0] SHAPE_ANNULUS  = 3'd0;
    localparam logic [2:0] SHAPE_WEDGE    = 3'd1;
    localparam logic [2:0] SHAPE_POLE     = 3'd2;
    localparam logic [2:0] SHAPE_DIPOLE   = 3'd3;
    localparam logic [2:0] SHAPE_QUASAR   = 3'd4;
    localparam logic [2:0] SHAPE_HEXAPOLE = 3'd5;

    // register indexes
    localparam logic [2:0] CFG_SHAPE_KIND  = 3'd0;
    localparam logic [2:0] CFG_ARG_A       = 3'd1;
    localparam logic [2:0] CFG_ARG_B       = 3'd2;
    localparam logic [2:0] CFG_WEDGE_WIDTH = 3'd3;

    localparam logic [31:0] ATAN_TURN32 [TAB_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] w;
    } ppsm_cfg_t;

    typedef struct packed {
        logic [15:0]          r;
        logic signed [15:0]   ang;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } ppsm_rot_t;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] xc;
        logic signed [15:0] yc;
    } ppsm_res_t;

    // rounded arctangent step of one cordic stage
    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic [32:0] s;
        s = {1'b0, ATAN_TURN32[i]} + (33'd1 << (31 - ANGLE_BITS));
        return ZW'(s >> (32 - ANGLE_BITS));
    endfunction

endpackage

@@ design/polar_pupil_shape_membership_core.sv @@
`timescale 1ns / 1ps

// polar pupil shape membership core
// input channel: push/full carries one polar point (radius q1.15, signed binary
//   angle); a transfer happens on a clock edge with push high and full low
// result channel: empty/pop; while empty is low the oldest result (inside_res,
//   x_coord, y_coord in q2.14) sits on the ports, a transfer on pop with empty low
// configuration: cfg_we/cfg_index/cfg_wdata write one of shape_kind, arg_a, arg_b
//   and wedge_width per write; only to be written while no point is in flight
// throughput: one point per cycle while full is low (fully pipelined cordic)
// from the input transfer to empty falling: front register at the transfer edge,
//   then one register per cordic stage, 3 test stages, 1 queue write
// a credit count of points accepted but not yet popped raises full once the
//   32-entry result queue could be filled, so a stalled receiver never loses
//   results and the pipeline itself never stops
// reset: registers return to annulus with inner sigma 0 and outer sigma 1,
//   pipeline and queue are emptied; no clearing pass is needed
module polar_pupil_shape_membership_core import ppsm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [15:0]        radius,
    input  logic signed [15:0] angle,
    output logic               empty,
    input  logic               pop,
    output logic               inside_res,
    output logic signed [15:0] x_coord,
    output logic signed [15:0] y_coord,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata
);

    ppsm_cfg_t      cfg_reg;
    logic [QAW:0]   credit_reg;
    logic           take, give;

    logic           f_valid, c_valid, t_valid;
    ppsm_rot_t      f_item, c_item;
    ppsm_res_t      t_res, q_res;

    assign take = push && !full;
    assign give = pop && !empty;
    assign full = (credit_reg == (QAW + 1)'(QDEPTH));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kind <= SHAPE_ANNULUS;
            cfg_reg.a    <= 16'd0;
            cfg_reg.b    <= 16'd16384;
            cfg_reg.w    <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SHAPE_KIND:  cfg_reg.kind <= cfg_wdata[2:0];
                CFG_ARG_A:       cfg_reg.a    <= cfg_wdata;
                CFG_ARG_B:       cfg_reg.b    <= cfg_wdata;
                CFG_WEDGE_WIDTH: cfg_reg.w    <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // points accepted but not yet popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            credit_reg <= '0;
        else
            credit_reg <= credit_reg + (QAW + 1)'(take) - (QAW + 1)'(give);
    end

    // front: accept, fold, gain compensation
    ppsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .radius    (radius),
        .angle     (angle),
        .out_valid (f_valid),
        .out_item  (f_item)
    );

    // back: rotation pipeline
    ppsm_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_item   (f_item),
        .out_valid (c_valid),
        .out_item  (c_item)
    );

    // back: shape tests and coordinate saturation
    ppsm_test u_test (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (c_valid),
        .in_item   (c_item),
        .out_valid (t_valid),
        .out_res   (t_res)
    );

    // result queue, sized to the credit limit
    ppsm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (t_valid),
        .wr_data (t_res),
        .rd_en   (pop),
        .empty   (empty),
        .rd_data (q_res)
    );

    assign inside_res = q_res.hit;
    assign x_coord    = q_res.xc;
    assign y_coord    = q_res.yc;

    // credit never passes the queue depth
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= (QAW + 1)'(QDEPTH))
        else $error("credit count above queue depth");

    // a waiting result implies an outstanding credit
    a_result_credit: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> credit_reg != '0)
        else $error("result waiting without credit");

    // no new point reaches the front while full
    a_front_full: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid |-> $past(!full))
        else $error("point accepted while full");

    // unused shape codes always report inside
    a_unused_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (t_valid && (cfg_reg.kind == 3'd6 || cfg_reg.kind == 3'd7)) |-> t_res.hit)
        else $error("unused shape code reported outside");

endmodule

@@ design/ppsm_front.sv @@
`timescale 1ns / 1ps

module ppsm_front import ppsm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [15:0]        radius,
    input  logic signed [15:0] angle,
    output logic               out_valid,
    output ppsm_rot_t          out_item
);

    localparam int UP = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int DN = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (ANGLE_BITS - 2);
    localparam logic signed [ZW-1:0] HALF    = ZW'(1) <<< (ANGLE_BITS - 1);

    logic                  valid_reg;
    ppsm_rot_t             item_reg;
    ppsm_rot_t             item_next;
    logic signed [ZW+15:0] zw;
    logic signed [ZW-1:0]  zs;
    logic signed [XW-1:0]  xm;

    always_comb
    begin
        zw = (ZW + 16)'(angle);
        zw = (zw <<< UP) >>> DN;
        zs = ZW'(zw);
        xm = signed'(XW'(radius) * XW'(INV_GAIN));
        item_next.r   = radius;
        item_next.ang = angle;
        item_next.y   = '0;
        item_next.x   = xm;
        item_next.z   = zs;
        // half-turn fold into [-90, 90] degrees
        if (zs > QUARTER)
        begin
            item_next.z = zs - HALF;
            item_next.x = -xm;
        end
        else if (zs < -QUARTER)
        begin
            item_next.z = zs + HALF;
            item_next.x = -xm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ design/ppsm_cordic.sv @@
`timescale 1ns / 1ps

module ppsm_cordic import ppsm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  ppsm_rot_t in_item,
    output logic      out_valid,
    output ppsm_rot_t out_item
);

    logic      vld [NUM_STAGES+1];
    ppsm_rot_t st  [NUM_STAGES+1];

    assign vld[0] = in_valid;
    assign st[0]  = in_item;

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_stage
        localparam logic signed [ZW-1:0] STEP = atan_step(i);
        logic      vld_reg;
        ppsm_rot_t st_reg;
        ppsm_rot_t st_next;

        always_comb
        begin
            st_next = st[i];
            if (st[i].z >= 0)
            begin
                st_next.x = st[i].x - (st[i].y >>> i);
                st_next.y = st[i].y + (st[i].x >>> i);
                st_next.z = st[i].z - STEP;
            end
            else
            begin
                st_next.x = st[i].x + (st[i].y >>> i);
                st_next.y = st[i].y - (st[i].x >>> i);
                st_next.z = st[i].z + STEP;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else
                vld_reg <= vld[i];
        end

        always_ff @(posedge clk)
        begin
            if (vld[i])
                st_reg <= st_next;
        end

        assign vld[i+1] = vld_reg;
        assign st[i+1]  = st_reg;
    end

    assign out_valid = vld[NUM_STAGES];
    assign out_item  = st[NUM_STAGES];

endmodule

@@ design/ppsm_test.sv @@
`timescale 1ns / 1ps

module ppsm_test import ppsm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  ppsm_cfg_t cfg,
    input  logic      in_valid,
    input  ppsm_rot_t in_item,
    output logic      out_valid,
    output ppsm_res_t out_res
);

    localparam logic signed [DW-1:0] ONE_DW  = DW'(32768);
    localparam logic signed [DW-1:0] TWO_DW  = DW'(65536);
    localparam logic signed [XW-1:0] RND_X   = XW'(65536);
    localparam logic signed [DW+17:0] RND_C  = (DW + 18)'(32768);

    // stage 1: rounding, centres and differences
    logic signed [XW-1:0]   xrf, yrf;
    logic signed [DW-1:0]   px, py, a2, b2, c2, dd, cx;
    logic signed [DW+17:0]  prod;
    logic signed [DW-1:0]   cxs [3];
    logic signed [DW-1:0]   cys [3];
    logic signed [17:0]     ang2, w18;
    logic                   band, wedge_ok;
    logic signed [15:0]     xs, ys;

    logic                   v1_reg;
    logic signed [DW-1:0]   dx_reg [3];
    logic signed [DW-1:0]   dy_reg [3];
    logic signed [DW-1:0]   rad_reg;
    logic                   band_reg, wedge_reg;
    logic signed [15:0]     xs_reg, ys_reg;

    // stage 2: squares
    logic                   v2_reg;
    logic signed [SQW-1:0]  sx_reg [3];
    logic signed [SQW-1:0]  sy_reg [3];
    logic signed [SQW-1:0]  sr_reg;
    logic                   band2_reg, wedge2_reg;
    logic signed [15:0]     xs2_reg, ys2_reg;

    // stage 3: compare and select
    logic                   in_c [3];
    logic                   hit_now;
    logic                   v3_reg;
    ppsm_res_t              res_reg;

    function automatic logic signed [15:0] sat16(input logic signed [DW-1:0] v);
        if (v > DW'(32767))
            return 16'sh7FFF;
        else if (v < -DW'(32768))
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    always_comb
    begin
        xrf  = (in_item.x + RND_X) >>> 17;
        yrf  = (in_item.y + RND_X) >>> 17;
        px   = signed'({xrf[DW-2:0], 1'b0});
        py   = signed'({yrf[DW-2:0], 1'b0});
        a2   = signed'({{(DW-17){1'b0}}, cfg.a, 1'b0});
        b2   = signed'({{(DW-17){1'b0}}, cfg.b, 1'b0});
        c2   = TWO_DW - a2;
        dd   = ONE_DW - signed'({{(DW-16){1'b0}}, cfg.a});
        prod = c2 * signed'({1'b0, COS30_Q16});
        cx   = DW'((prod + RND_C) >>> 16);

        cxs[0] = c2;
        cys[0] = '0;
        cxs[1] = dd;
        cys[1] = dd;
        cxs[2] = dd;
        cys[2] = -dd;
        if (cfg.kind == SHAPE_POLE)
            cxs[0] = a2;
        else if (cfg.kind == SHAPE_HEXAPOLE)
        begin
            cxs[0] = cx;
            cys[0] = -dd;
            cxs[1] = cx;
        end

        band = ({1'b0, in_item.r} > {cfg.a, 1'b0}) && ({1'b0, in_item.r} < {cfg.b, 1'b0});
        ang2 = signed'({in_item.ang[15], in_item.ang, 1'b0});
        w18  = signed'({2'b00, cfg.w});
        wedge_ok = (ang2 > -w18) && (ang2 < w18);
        xs = sat16(DW'(xrf));
        ys = sat16(DW'(yrf));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dx_reg[k] <= px - cxs[k];
                dy_reg[k] <= py - cys[k];
            end
            rad_reg   <= (cfg.kind == SHAPE_POLE) ? b2 : ONE_DW;
            band_reg  <= band;
            wedge_reg <= wedge_ok;
            xs_reg    <= xs;
            ys_reg    <= ys;
        end
        if (v1_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sx_reg[k] <= dx_reg[k] * dx_reg[k];
                sy_reg[k] <= dy_reg[k] * dy_reg[k];
            end
            sr_reg     <= rad_reg * rad_reg;
            band2_reg  <= band_reg;
            wedge2_reg <= wedge_reg;
            xs2_reg    <= xs_reg;
            ys2_reg    <= ys_reg;
        end
        if (v2_reg)
        begin
            res_reg.hit <= hit_now;
            res_reg.xc  <= xs2_reg;
            res_reg.yc  <= ys2_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            in_c[k] = ((SQW + 1)'(sx_reg[k]) + (SQW + 1)'(sy_reg[k])) < (SQW + 1)'(sr_reg);
        case (cfg.kind)
            SHAPE_ANNULUS:  hit_now = band2_reg;
            SHAPE_WEDGE:    hit_now = band2_reg && wedge2_reg;
            SHAPE_POLE:     hit_now = in_c[0];
            SHAPE_DIPOLE:   hit_now = in_c[0];
            SHAPE_QUASAR:   hit_now = in_c[0] && in_c[1] && in_c[2];
            SHAPE_HEXAPOLE: hit_now = in_c[0] && in_c[1];
            default:        hit_now = 1'b1;
        endcase
    end

    assign out_valid = v3_reg;
    assign out_res   = res_reg;

endmodule

@@ design/ppsm_queue.sv @@
`timescale 1ns / 1ps

module ppsm_queue import ppsm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  ppsm_res_t wr_data,
    input  logic      rd_en,
    output logic      empty,
    output ppsm_res_t rd_data
);

    ppsm_res_t      mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   level_reg;
    logic           do_rd;

    assign empty   = (level_reg == '0);
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            level_reg <= level_reg + (QAW + 1)'(wr_en) - (QAW + 1)'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule
